@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes and sequencer states for the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   // default operand width and fixed result widths
   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RESULT_WIDTH      = 32;
   localparam int ACTION_WIDTH      = 4;
   localparam int RSP_DATA_WIDTH    = 2 * RESULT_WIDTH;
   localparam int RSP_USER_WIDTH    = 2;

   // operation codes carried in the request tuser
   localparam logic [ACTION_WIDTH-1:0] ACT_ADD     = 4'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_SUB     = 4'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_MUL     = 4'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_DIV     = 4'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_ADD_RAW = 4'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_SUB_RAW = 4'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_MUL_RAW = 4'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_DIV_RAW = 4'd7;
   localparam logic [ACTION_WIDTH-1:0] ACT_GREATER = 4'd8;
   localparam logic [ACTION_WIDTH-1:0] ACT_LESS    = 4'd9;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_D,
      ST_SUM,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIV_NUM_GO,
      ST_DIV_NUM_WAIT,
      ST_DIV_DEN_GO,
      ST_DIV_DEN_WAIT,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/rau_mul.sv @@
// ----------------------------------------------------------------------------
// Rational unit multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic signed [OPERAND_WIDTH-1:0] a,
   input  logic signed [OPERAND_WIDTH-1:0] b,
   output logic signed [2*OPERAND_WIDTH-1:0] p
);

   logic signed [2*OPERAND_WIDTH-1:0] p_ff;
   logic signed [2*OPERAND_WIDTH-1:0] p_in;

   // form the full-width product
   assign p_in = a * b;

   // register the product
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

@@ hw/rtl/rau_gcd.sv @@
// ----------------------------------------------------------------------------
// Rational unit gcd engine
// Binary gcd over two magnitudes, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
   parameter int MAG_WIDTH = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_WIDTH-1:0] a,
   input  logic [MAG_WIDTH-1:0] b,
   output logic                 done,
   output logic [MAG_WIDTH-1:0] g
);

   localparam int KW = $clog2(MAG_WIDTH);

   logic [MAG_WIDTH-1:0] a_ff, a_in;
   logic [MAG_WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MAG_WIDTH-1:0] g_ff, g_in;
   logic [MAG_WIDTH-1:0] a_minus_b;
   logic [MAG_WIDTH-1:0] b_minus_a;

   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   // one step of the binary gcd
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      g_in    = g_ff;
      if (start) begin
         a_in   = a;
         b_in   = b;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            g_in    = (a_ff | b_ff) << k_ff;
            done_in = 1'b1;
            run_in  = 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_minus_b >> 1;
         end else begin
            b_in = b_minus_a >> 1;
         end
      end
   end

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

@@ hw/rtl/rau_div.sv @@
// ----------------------------------------------------------------------------
// Rational unit divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int MAG_WIDTH = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_WIDTH-1:0] dividend,
   input  logic [MAG_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [MAG_WIDTH-1:0] quotient
);

   localparam int CW = $clog2(MAG_WIDTH);

   logic [MAG_WIDTH-1:0] quo_ff, quo_in;
   logic [MAG_WIDTH-1:0] rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MAG_WIDTH:0]   shifted;
   logic [MAG_WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[MAG_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   // shift in one dividend bit and try the subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(MAG_WIDTH - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[MAG_WIDTH]) begin
            rem_in = diff[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Sequence: raw, compare and unused codes take three passes through the shared
//   multiplier, the sum and the load of the result register, which waits until
//   the output register is free; a new beat is taken only in the idle state.
// Reduced codes add a binary gcd and, unless the gcd is zero, two restoring
//   divisions (numerator, then denominator) before that load; one item at a time.
// Synchronous reset clears the sequencer and the result valid; no memory.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // request beat
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: first_num, first_den, second_num, second_den (lowest bits first)
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   req_tdata,
   // tuser: action
   input  logic [rau_pkg::ACTION_WIDTH-1:0]       req_tuser,
   // result beat
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: result_num, result_den (lowest bits first)
   output logic [rau_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // tuser: compare_true, error (lowest bit first)
   output logic [rau_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser
);

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int EW = (SW > rau_pkg::RESULT_WIDTH) ? SW : rau_pkg::RESULT_WIDTH;
   localparam int RW = rau_pkg::RESULT_WIDTH;

   rau_pkg::state_type state_ff, state_in;

   logic [rau_pkg::ACTION_WIDTH-1:0] act_ff, act_in;
   logic signed [W-1:0]  n1_ff, n1_in, d1_ff, d1_in, n2_ff, n2_in, d2_ff, d2_in;
   logic signed [MW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [SW-1:0] num_ff, num_in, den_ff, den_in;
   logic [MW-1:0]        g_ff, g_in;
   logic                 cmp_ff, cmp_in, err_ff, err_in;

   logic                              rsp_tvalid_ff, rsp_tvalid_in;
   logic [rau_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [rau_pkg::RSP_USER_WIDTH-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic signed [W-1:0]  mul_a, mul_b;
   logic signed [MW-1:0] mul_p;
   logic                 gcd_start, gcd_done;
   logic [MW-1:0]        gcd_g;
   logic                 div_start, div_done;
   logic [MW-1:0]        div_dividend, div_quotient;

   logic [MW-1:0]        num_mag, den_mag;
   logic signed [SW-1:0] quo_signed;
   logic signed [SW-1:0] pa_ext, pb_ext;
   logic signed [EW-1:0] num_wide, den_wide;
   logic                 is_mul, is_div, accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == rau_pkg::ST_IDLE);
   assign is_mul     = (act_ff[1:0] == rau_pkg::ACT_MUL[1:0]);
   assign is_div     = (act_ff[1:0] == rau_pkg::ACT_DIV[1:0]);

   // magnitudes and sign handling of the working fraction
   assign num_mag    = num_ff[SW-1] ? MW'(-num_ff) : MW'(num_ff);
   assign den_mag    = den_ff[SW-1] ? MW'(-den_ff) : MW'(den_ff);
   assign quo_signed = $signed({1'b0, div_quotient});
   assign pa_ext     = SW'(pa_ff);
   assign pb_ext     = SW'(pb_ff);
   assign num_wide   = EW'(num_ff);
   assign den_wide   = EW'(den_ff);

   // shared units
   rau_mul #(.OPERAND_WIDTH(W)) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   rau_gcd #(.MAG_WIDTH(MW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (num_mag),
      .b     (den_mag),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div #(.MAG_WIDTH(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      n1_in         = n1_ff;
      d1_in         = d1_ff;
      n2_in         = n2_ff;
      d2_in         = d2_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      g_in          = g_ff;
      cmp_in        = cmp_ff;
      err_in        = err_ff;
      mul_a         = n1_ff;
      mul_b         = d2_ff;
      gcd_start     = 1'b0;
      div_start     = 1'b0;
      div_dividend  = num_mag;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (accept) begin
               act_in   = req_tuser;
               n1_in    = req_tdata[W-1:0];
               d1_in    = req_tdata[2*W-1:W];
               n2_in    = req_tdata[3*W-1:2*W];
               d2_in    = req_tdata[4*W-1:3*W];
               cmp_in   = 1'b0;
               err_in   = 1'b0;
               state_in = rau_pkg::ST_MUL_A;
            end
         end
         rau_pkg::ST_MUL_A: begin
            // first numerator product
            mul_a    = n1_ff;
            mul_b    = is_mul ? n2_ff : d2_ff;
            state_in = rau_pkg::ST_MUL_B;
         end
         rau_pkg::ST_MUL_B: begin
            mul_a    = n2_ff;
            mul_b    = d1_ff;
            pa_in    = mul_p;
            state_in = rau_pkg::ST_MUL_D;
         end
         rau_pkg::ST_MUL_D: begin
            // denominator product
            mul_a    = d1_ff;
            mul_b    = is_div ? n2_ff : d2_ff;
            pb_in    = mul_p;
            state_in = rau_pkg::ST_SUM;
         end
         rau_pkg::ST_SUM: begin
            den_in = SW'(mul_p);
            case (act_ff[1:0])
               rau_pkg::ACT_ADD[1:0]: num_in = pa_ext + pb_ext;
               rau_pkg::ACT_SUB[1:0]: num_in = pa_ext - pb_ext;
               default:               num_in = pa_ext;
            endcase
            if (act_ff == rau_pkg::ACT_GREATER) begin
               cmp_in = (pa_ff > pb_ff);
            end else if (act_ff == rau_pkg::ACT_LESS) begin
               cmp_in = (pa_ff < pb_ff);
            end
            if (act_ff inside {[rau_pkg::ACT_ADD:rau_pkg::ACT_DIV]}) begin
               state_in = rau_pkg::ST_GCD_GO;
            end else begin
               state_in = rau_pkg::ST_DONE;
            end
         end
         rau_pkg::ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = rau_pkg::ST_GCD_WAIT;
         end
         rau_pkg::ST_GCD_WAIT: begin
            if (gcd_done) begin
               g_in = gcd_g;
               if (gcd_g == '0) begin
                  // numerator and denominator both zero: flag and clear the fraction
                  err_in   = 1'b1;
                  num_in   = '0;
                  den_in   = '0;
                  state_in = rau_pkg::ST_DONE;
               end else begin
                  state_in = rau_pkg::ST_DIV_NUM_GO;
               end
            end
         end
         rau_pkg::ST_DIV_NUM_GO: begin
            div_start    = 1'b1;
            div_dividend = num_mag;
            state_in     = rau_pkg::ST_DIV_NUM_WAIT;
         end
         rau_pkg::ST_DIV_NUM_WAIT: begin
            if (div_done) begin
               num_in   = num_ff[SW-1] ? -quo_signed : quo_signed;
               state_in = rau_pkg::ST_DIV_DEN_GO;
            end
         end
         rau_pkg::ST_DIV_DEN_GO: begin
            div_start    = 1'b1;
            div_dividend = den_mag;
            state_in     = rau_pkg::ST_DIV_DEN_WAIT;
         end
         rau_pkg::ST_DIV_DEN_WAIT: begin
            if (div_done) begin
               den_in   = den_ff[SW-1] ? -quo_signed : quo_signed;
               state_in = rau_pkg::ST_DONE;
            end
         end
         rau_pkg::ST_DONE: begin
            // load the result beat once the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               if (act_ff inside {[rau_pkg::ACT_ADD:rau_pkg::ACT_DIV_RAW]}) begin
                  rsp_tdata_in = {den_wide[RW-1:0], num_wide[RW-1:0]};
               end else begin
                  rsp_tdata_in = '0;
               end
               rsp_tuser_in = {err_ff, cmp_ff};
               state_in     = rau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rau_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rau_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      n1_ff        <= n1_in;
      d1_ff        <= d1_in;
      n2_ff        <= n2_in;
      d2_ff        <= d2_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      g_ff         <= g_in;
      cmp_ff       <= cmp_in;
      err_ff       <= err_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // an error beat carries a zero fraction
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff[1] |-> rsp_tdata_ff == '0)
      else $error("error beat with nonzero fraction");

   // compare and error never come together
   a_cmp_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff[0] |-> !rsp_tuser_ff[1])
      else $error("compare flag set together with error");

   // gcd completes only while the sequencer waits for it
   a_gcd_wait: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> state_ff == rau_pkg::ST_GCD_WAIT)
      else $error("gcd done outside its wait state");

   // divider completes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == rau_pkg::ST_DIV_NUM_WAIT ||
                   state_ff == rau_pkg::ST_DIV_DEN_WAIT)
      else $error("divider done outside its wait states");

   // a new result beat comes only from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == rau_pkg::ST_DONE)
      else $error("result beat raised outside done state");

endmodule
